// ----- hw/rtl/abe_pkg.sv -----
// ----------------------------------------------------------------------------
// abe_pkg
// Shared types and constants of the allocation bitmap engine: operation codes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package abe_pkg;

  localparam int MODE_W        = 3;
  localparam int IDX_W         = 13;
  localparam int FIDX_W        = 12;
  localparam int NUM_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET     = 3'd0,
    MODE_CLR     = 3'd1,
    MODE_READ    = 3'd2,
    MODE_FFS     = 3'd3,
    MODE_FFC     = 3'd4,
    MODE_SET_ALL = 3'd5,
    MODE_CLR_ALL = 3'd6,
    MODE_RESIZE  = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_RD,
    ST_MOD,
    ST_SWEEP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic sweep_zero;
    logic div_mul;
    logic div_fix;
    logic modify;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    mode_t in_op;
    mode_t op;
    logic  in_oob;
    logic  in_over;
    logic  sweep_end_all;
    logic  sweep_end_fill;
    logic  scan_end;
    logic  out_free;
  } sts_t;

endpackage

// ----- hw/rtl/abe_req_if.sv -----
// ----------------------------------------------------------------------------
// abe_req_if
// Request channel of the allocation bitmap engine: operation and bit index.
// ----------------------------------------------------------------------------
interface abe_req_if;
  logic                         valid;
  logic                         ready;
  logic [abe_pkg::MODE_W-1:0]   mode;
  logic [abe_pkg::IDX_W-1:0]    bit_index;

  modport source (output valid, mode, bit_index, input ready);
  modport sink (input valid, mode, bit_index, output ready);
endinterface

// ----- hw/rtl/abe_rsp_if.sv -----
// ----------------------------------------------------------------------------
// abe_rsp_if
// Response channel of the allocation bitmap engine: one response per request.
// ----------------------------------------------------------------------------
interface abe_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic                         bit_value;
  logic                         found;
  logic [abe_pkg::FIDX_W-1:0]   found_index;

  modport source (output valid, status, bit_value, found, found_index, input ready);
  modport sink (input valid, status, bit_value, found, found_index, output ready);
endinterface

// ----- hw/rtl/allocation_bitmap_engine.sv -----
// ----------------------------------------------------------------------------
// allocation_bitmap_engine
// A page-allocation bitmap of NUM_BITS bits with a live size limit, held in a
// RAM of ceil(NUM_BITS/WORD_BITS) words and served one request at a time.
// After reset the block runs a clearing pass over every word before it takes
// its first request. Set, clear and read of one bit run a reciprocal
// multiply and a correction for the word/offset split, a RAM read and, for
// set and clear, a write-back. Find-first-set, find-first-clear, set-all and
// shrinking resize walk the word RAM one word per cycle below the limit (a
// find stops at its first match); clear-all walks every word. A resize that
// grows or keeps the size, and any out-of-range request, go straight to the
// response. A finished response waits in an output register, and the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
module allocation_bitmap_engine #(
  parameter int NUM_BITS  = abe_pkg::NUM_BITS_DEF,
  parameter int WORD_BITS = abe_pkg::WORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  abe_req_if.sink    req,
  abe_rsp_if.source  rsp
);

  abe_pkg::cmd_t cmd;
  abe_pkg::sts_t sts;

  abe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .ready (req.ready),
    .sts   (sts),
    .cmd   (cmd)
  );

  abe_dpath #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (req.mode),
    .bit_index   (req.bit_index),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .bit_value   (rsp.bit_value),
    .found       (rsp.found),
    .found_index (rsp.found_index)
  );

endmodule

// ----- hw/rtl/abe_ram.sv -----
// ----------------------------------------------------------------------------
// abe_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module abe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/abe_ctrl.sv -----
// ----------------------------------------------------------------------------
// abe_ctrl
// Controller of the allocation bitmap engine. Sequences the clearing pass
// after reset, single-bit read-modify-write, write sweeps and read scans.
// ----------------------------------------------------------------------------
module abe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  abe_pkg::sts_t   sts,
  output abe_pkg::cmd_t   cmd
);

  abe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abe_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      abe_pkg::ST_INIT: begin
        if (sts.sweep_end_all) begin
          state_next = abe_pkg::ST_IDLE;
        end
      end
      abe_pkg::ST_IDLE: begin
        if (valid) begin
          unique case (sts.in_op) inside
            abe_pkg::MODE_SET, abe_pkg::MODE_CLR, abe_pkg::MODE_READ: begin
              state_next = sts.in_oob ? abe_pkg::ST_DONE : abe_pkg::ST_DIV;
            end
            abe_pkg::MODE_FFS, abe_pkg::MODE_FFC: begin
              state_next = abe_pkg::ST_SCAN;
            end
            abe_pkg::MODE_SET_ALL, abe_pkg::MODE_CLR_ALL: begin
              state_next = abe_pkg::ST_SWEEP;
            end
            default: begin
              // Growing or keeping the size needs no clearing.
              state_next = (sts.in_over || sts.in_oob) ? abe_pkg::ST_DONE
                                                       : abe_pkg::ST_SCAN;
            end
          endcase
        end
      end
      abe_pkg::ST_DIV:   state_next = abe_pkg::ST_FIX;
      abe_pkg::ST_FIX:   state_next = abe_pkg::ST_RD;
      abe_pkg::ST_RD:    state_next = abe_pkg::ST_MOD;
      abe_pkg::ST_MOD:   state_next = abe_pkg::ST_DONE;
      abe_pkg::ST_SWEEP: begin
        if ((sts.op == abe_pkg::MODE_CLR_ALL) ? sts.sweep_end_all : sts.sweep_end_fill) begin
          state_next = abe_pkg::ST_DONE;
        end
      end
      abe_pkg::ST_SCAN: begin
        if (sts.scan_end) begin
          state_next = abe_pkg::ST_DONE;
        end
      end
      abe_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = abe_pkg::ST_IDLE;
        end
      end
      default: state_next = abe_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd   = '0;
    ready = 1'b0;
    unique case (state)
      abe_pkg::ST_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = 1'b1;
      end
      abe_pkg::ST_IDLE: begin
        ready      = 1'b1;
        cmd.accept = valid;
      end
      abe_pkg::ST_DIV:   cmd.div_mul = 1'b1;
      abe_pkg::ST_FIX:   cmd.div_fix = 1'b1;
      abe_pkg::ST_RD:    ;
      abe_pkg::ST_MOD:   cmd.modify = 1'b1;
      abe_pkg::ST_SWEEP: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = (sts.op == abe_pkg::MODE_CLR_ALL);
      end
      abe_pkg::ST_SCAN:  cmd.scan = 1'b1;
      abe_pkg::ST_DONE:  cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  // Every accepted request must leave idle, or a response would be lost.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state != abe_pkg::ST_IDLE)
    else $error("accepted request did not start");

endmodule

// ----- hw/rtl/abe_dpath.sv -----
// ----------------------------------------------------------------------------
// abe_dpath
// Datapath of the allocation bitmap engine: word store, limit register,
// word/offset split of a bit index, sweep and scan counters, priority
// encoder and the response register.
// ----------------------------------------------------------------------------
module abe_dpath #(
  parameter int NUM_BITS  = abe_pkg::NUM_BITS_DEF,
  parameter int WORD_BITS = abe_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  abe_pkg::cmd_t                cmd,
  output abe_pkg::sts_t                sts,
  input  logic [abe_pkg::MODE_W-1:0]   mode,
  input  logic [abe_pkg::IDX_W-1:0]    bit_index,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         status,
  output logic                         bit_value,
  output logic                         found,
  output logic [abe_pkg::FIDX_W-1:0]   found_index
);

  localparam int IW    = abe_pkg::IDX_W;
  localparam int FW    = abe_pkg::FIDX_W;
  localparam int DEPTH = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int OW    = $clog2(WORD_BITS);
  localparam int LW    = $clog2(NUM_BITS + 1);
  localparam int BW    = $clog2(DEPTH * WORD_BITS + WORD_BITS + 1);
  localparam int CW    = (LW > IW ? LW : IW) + 1;
  localparam int RECIP = (1 << IW) / WORD_BITS;
  localparam int RW    = $clog2(RECIP + 1);

  // Mask of the bits of the word starting at b whose position is below t.
  function automatic logic [WORD_BITS-1:0] below_mask(input logic [BW-1:0] b,
                                                      input logic [BW-1:0] t);
    logic [BW-1:0]        span;
    logic [WORD_BITS-1:0] m;
    span = t - b;
    if (t <= b) begin
      m = '0;
    end else if (span >= BW'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = ~({WORD_BITS{1'b1}} << span[OW-1:0]);
    end
    return m;
  endfunction

  abe_pkg::mode_t       in_op, op;
  logic [IW-1:0]        idx;
  logic [LW-1:0]        limit, thr;
  logic [RW-1:0]        q0;
  logic [AW-1:0]        word_addr, addr, p_addr;
  logic [OW-1:0]        bit_off, hit_off;
  logic [BW-1:0]        base, p_base;
  logic                 p_valid;
  logic                 res_status, res_value, res_found;
  logic [FW-1:0]        res_fidx;

  logic                 in_oob, in_over;
  logic [IW+RW-1:0]     prod;
  logic [IW-1:0]        qw, rem, q_fix, r_fix;
  logic                 corr;
  logic                 below_lim, hit, issue, scan_end;
  logic [WORD_BITS-1:0] sweep_mask, p_mask, match, bit_mask;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  assign in_op   = abe_pkg::mode_t'(mode);
  assign in_oob  = CW'(bit_index) >= CW'(limit);
  assign in_over = CW'(bit_index) > CW'(NUM_BITS);

  // Word index by reciprocal multiply; the estimate is at most one low.
  assign prod  = (IW+RW)'(idx) * (IW+RW)'(RECIP);
  assign qw    = IW'(q0) * IW'(WORD_BITS);
  assign rem   = idx - qw;
  assign corr  = rem >= IW'(WORD_BITS);
  assign q_fix = IW'(q0) + IW'(corr);
  assign r_fix = corr ? rem - IW'(WORD_BITS) : rem;

  assign sweep_mask = below_mask(base, BW'(thr));
  assign p_mask     = below_mask(p_base, BW'(thr));
  assign match      = ((op == abe_pkg::MODE_FFS) ? rdata : ~rdata) & p_mask;
  assign hit        = p_valid && (op == abe_pkg::MODE_FFS || op == abe_pkg::MODE_FFC)
                      && (|match);
  assign below_lim  = base < BW'(limit);
  assign issue      = cmd.scan && below_lim && !hit;
  assign scan_end   = hit || (!below_lim && !p_valid);
  assign bit_mask   = WORD_BITS'(1) << bit_off;

  always_comb begin
    hit_off = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_off = OW'(i);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = word_addr;
    wdata = (op == abe_pkg::MODE_SET) ? (rdata | bit_mask) : (rdata & ~bit_mask);
    if (cmd.sweep) begin
      we    = cmd.sweep_zero || (base < BW'(thr));
      waddr = addr;
      wdata = cmd.sweep_zero ? '0 : sweep_mask;
    end else if (cmd.scan) begin
      // Shrinking: drop the bits at or beyond the new limit.
      we    = p_valid && (op == abe_pkg::MODE_RESIZE);
      waddr = p_addr;
      wdata = rdata & p_mask;
    end else if (cmd.modify) begin
      we    = (op == abe_pkg::MODE_SET) || (op == abe_pkg::MODE_CLR);
    end
  end

  assign raddr = cmd.scan ? addr : word_addr;

  abe_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      base      <= '0;
      p_valid   <= 1'b0;
      limit     <= LW'(NUM_BITS);
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        addr <= '0;
        base <= '0;
      end else if (cmd.sweep || issue) begin
        addr <= addr + AW'(1);
        base <= base + BW'(WORD_BITS);
      end
      p_valid <= issue;
      if (cmd.accept && in_op == abe_pkg::MODE_RESIZE && !in_over && in_oob) begin
        limit <= LW'(bit_index);
      end else if (cmd.scan && scan_end && op == abe_pkg::MODE_RESIZE) begin
        limit <= thr;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_addr <= addr;
      p_base <= base;
    end
    if (cmd.accept) begin
      op         <= in_op;
      idx        <= bit_index;
      thr        <= (in_op == abe_pkg::MODE_RESIZE) ? LW'(bit_index) : limit;
      res_status <= ((in_op == abe_pkg::MODE_SET || in_op == abe_pkg::MODE_CLR ||
                      in_op == abe_pkg::MODE_READ) && in_oob) ||
                    (in_op == abe_pkg::MODE_RESIZE && in_over);
      res_value  <= 1'b0;
      res_found  <= 1'b0;
      res_fidx   <= '0;
    end
    if (cmd.div_mul) begin
      q0 <= prod[IW+RW-1:IW];
    end
    if (cmd.div_fix) begin
      word_addr <= AW'(q_fix);
      bit_off   <= OW'(r_fix);
    end
    if (cmd.modify && op == abe_pkg::MODE_READ) begin
      res_value <= rdata[bit_off];
    end
    if (cmd.scan && hit) begin
      res_found <= 1'b1;
      res_fidx  <= FW'(p_base + BW'(hit_off));
    end
    if (cmd.load_out) begin
      status      <= res_status;
      bit_value   <= res_value;
      found       <= res_found;
      found_index <= res_fidx;
    end
  end

  assign sts.in_op          = in_op;
  assign sts.op             = op;
  assign sts.in_oob         = in_oob;
  assign sts.in_over        = in_over;
  assign sts.sweep_end_all  = addr == AW'(DEPTH - 1);
  assign sts.sweep_end_fill = (base + BW'(WORD_BITS)) >= BW'(thr);
  assign sts.scan_end       = scan_end;
  assign sts.out_free       = !rsp_valid || rsp_ready;

  a_limit_range: assert property (@(posedge clk) disable iff (rst)
    limit <= LW'(NUM_BITS))
    else $error("limit beyond capacity");

  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr <= AW'(DEPTH - 1))
    else $error("store write beyond last word");

  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> !status && !bit_value)
    else $error("find response carries stray fields");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the allocation bitmap engine. A shadow bitmap and
// limit predict every response. Directed tests cover single-bit operations,
// bulk fills, finds, resizing and one long receiver stall. Random traffic
// then runs under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IW          = abe_pkg::IDX_W;
  localparam int MAP_BITS    = abe_pkg::NUM_BITS_DEF;
  localparam int IDX_MAX     = (1 << abe_pkg::IDX_W) - 1;
  localparam int RUN_LIMIT   = 600000;
  localparam int TAIL_CYCLES = 200;
  localparam int STALL_LEN   = 400;

  typedef struct packed {
    logic                       status;
    logic                       bit_value;
    logic                       found;
    logic [abe_pkg::FIDX_W-1:0] found_index;
  } alloc_reply_t;

  logic clk;
  logic rst;

  abe_req_if req_ch ();
  abe_rsp_if rsp_ch ();

  allocation_bitmap_engine uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [MAP_BITS-1:0] shadow_map;
  int                  shadow_limit;
  alloc_reply_t        pending_replies[$];

  int err_count    = 0;
  int reply_count  = 0;
  int cycle_count  = 0;
  int req_idle_pct = 0;
  int rsp_idle_pct = 0;
  int stall_left   = 0;
  int mode_count[8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one request to the shadow bitmap and returns the response it
  // should produce.
  function automatic alloc_reply_t apply_request(abe_pkg::mode_t op, logic [IW-1:0] idx);
    alloc_reply_t r;
    int           i;
    r = '0;
    case (op) inside
      abe_pkg::MODE_SET, abe_pkg::MODE_CLR: begin
        if (int'(idx) >= shadow_limit) r.status = 1'b1;
        else shadow_map[idx] = (op == abe_pkg::MODE_SET);
      end
      abe_pkg::MODE_READ: begin
        if (int'(idx) >= shadow_limit) r.status = 1'b1;
        else r.bit_value = shadow_map[idx];
      end
      abe_pkg::MODE_FFS, abe_pkg::MODE_FFC: begin
        for (i = 0; i < shadow_limit; i++) begin
          if (shadow_map[i] == (op == abe_pkg::MODE_FFS)) begin
            r.found       = 1'b1;
            r.found_index = i[abe_pkg::FIDX_W-1:0];
            break;
          end
        end
      end
      abe_pkg::MODE_SET_ALL: begin
        for (i = 0; i < shadow_limit; i++) shadow_map[i] = 1'b1;
      end
      abe_pkg::MODE_CLR_ALL: begin
        shadow_map = '0;
      end
      default: begin
        if (int'(idx) > MAP_BITS) begin
          r.status = 1'b1;
        end else begin
          // Bits dropped by a shrink are cleared so they read zero later.
          for (i = int'(idx); i < shadow_limit; i++) shadow_map[i] = 1'b0;
          shadow_limit = int'(idx);
        end
      end
    endcase
    return r;
  endfunction

  // Offers one request from a falling edge and returns at the rising edge
  // where the transaction completes.
  task automatic send_request(abe_pkg::mode_t op, logic [IW-1:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= op;
    req_ch.bit_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    pending_replies.push_back(apply_request(op, idx));
    mode_count[op]++;
  endtask

  // Lowers valid and waits, at a rising edge, until every response is back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic set_idling(int req_pct, int rsp_pct);
    req_idle_pct = req_pct;
    rsp_idle_pct = rsp_pct;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: random idling, or a counted hold-off while stall_left runs.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : reply_check
    alloc_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        err_count++;
        $display("%0t: response with none expected, actual status %0d found %0d index %0d",
                 $time, rsp_ch.status, rsp_ch.found, rsp_ch.found_index);
      end else begin
        want = pending_replies.pop_front();
        check_field("status", int'(want.status), int'(rsp_ch.status));
        check_field("bit_value", int'(want.bit_value), int'(rsp_ch.bit_value));
        check_field("found", int'(want.found), int'(rsp_ch.found));
        check_field("found_index", int'(want.found_index), int'(rsp_ch.found_index));
        reply_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_count, pending_replies.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_single_bit_ops();
    send_request(abe_pkg::MODE_READ, '0);
    send_request(abe_pkg::MODE_SET, '0);
    send_request(abe_pkg::MODE_READ, '0);
    send_request(abe_pkg::MODE_SET, IW'(MAP_BITS - 1));
    send_request(abe_pkg::MODE_SET, IW'(MAP_BITS));
    send_request(abe_pkg::MODE_READ, IW'(IDX_MAX));
    send_request(abe_pkg::MODE_CLR, '0);
    send_request(abe_pkg::MODE_FFS, '0);
    send_request(abe_pkg::MODE_FFC, '0);
    drain();
  endtask

  task automatic test_bulk_ops();
    send_request(abe_pkg::MODE_SET_ALL, '0);
    send_request(abe_pkg::MODE_FFC, '0);
    send_request(abe_pkg::MODE_CLR, IW'(100));
    send_request(abe_pkg::MODE_FFC, '0);
    send_request(abe_pkg::MODE_CLR_ALL, IW'(IDX_MAX));
    send_request(abe_pkg::MODE_FFS, '0);
    drain();
  endtask

  task automatic test_resize();
    send_request(abe_pkg::MODE_RESIZE, IW'(IDX_MAX));
    send_request(abe_pkg::MODE_RESIZE, IW'(MAP_BITS));
    send_request(abe_pkg::MODE_SET_ALL, '0);
    send_request(abe_pkg::MODE_RESIZE, IW'(40));
    send_request(abe_pkg::MODE_READ, IW'(40));
    send_request(abe_pkg::MODE_RESIZE, IW'(MAP_BITS));
    send_request(abe_pkg::MODE_FFC, '0);
    send_request(abe_pkg::MODE_RESIZE, '0);
    send_request(abe_pkg::MODE_FFS, '0);
    send_request(abe_pkg::MODE_FFC, '0);
    send_request(abe_pkg::MODE_SET, '0);
    send_request(abe_pkg::MODE_RESIZE, IW'(MAP_BITS));
    drain();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the output register fills and the request channel stalls.
  task automatic test_backpressure();
    int n;
    set_idling(0, 0);
    @(posedge clk);
    stall_left = STALL_LEN;
    for (n = 0; n < 12; n++) begin
      send_request(n[0] ? abe_pkg::MODE_READ : abe_pkg::MODE_SET,
                   IW'($urandom_range(0, MAP_BITS - 1)));
    end
    drain();
  endtask

  function automatic logic [IW-1:0] pick_index();
    if (shadow_limit > 0 && $urandom_range(0, 99) < 85)
      return IW'($urandom_range(0, shadow_limit - 1));
    else if ($urandom_range(0, 1) == 0)
      return IW'(shadow_limit);
    else
      return IW'($urandom_range(shadow_limit, IDX_MAX));
  endfunction

  function automatic logic [IW-1:0] pick_size();
    int s;
    s = $urandom_range(0, 9);
    if (s < 4) return IW'($urandom_range(0, 96));
    else if (s < 7) return IW'(MAP_BITS);
    else if (s < 9) return IW'($urandom_range(0, MAP_BITS));
    else return IW'($urandom_range(MAP_BITS + 1, IDX_MAX));
  endfunction

  task automatic test_random_traffic(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 22) send_request(abe_pkg::MODE_SET, pick_index());
      else if (r < 40) send_request(abe_pkg::MODE_CLR, pick_index());
      else if (r < 55) send_request(abe_pkg::MODE_READ, pick_index());
      else if (r < 67) send_request(abe_pkg::MODE_FFS, IW'($urandom_range(0, IDX_MAX)));
      else if (r < 79) send_request(abe_pkg::MODE_FFC, IW'($urandom_range(0, IDX_MAX)));
      else if (r < 83) send_request(abe_pkg::MODE_SET_ALL, IW'($urandom_range(0, IDX_MAX)));
      else if (r < 86) send_request(abe_pkg::MODE_CLR_ALL, IW'($urandom_range(0, IDX_MAX)));
      else if (r < 92) send_request(abe_pkg::MODE_RESIZE, pick_size());
      else send_request(abe_pkg::mode_t'($urandom_range(0, 7)),
                        IW'($urandom_range(0, IDX_MAX)));
    end
    drain();
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.mode      = abe_pkg::MODE_SET;
    req_ch.bit_index = '0;
    shadow_map       = '0;
    shadow_limit     = MAP_BITS;
    foreach (mode_count[m]) mode_count[m] = 0;
    set_idling(9, 82);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_bit_ops();
    test_bulk_ops();
    test_resize();
    test_backpressure();

    set_idling(9, 82);
    test_random_traffic(230);
    set_idling(82, 9);
    test_random_traffic(230);
    set_idling(0, 0);
    test_random_traffic(230);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected responses never arrived", $time, pending_replies.size());
    end
    $display("Checked %0d responses under three idling mixes and a long receiver stall.",
             reply_count);
    $display("Requests: set %0d clr %0d read %0d ffs %0d ffc %0d setall %0d clrall %0d rsz %0d",
             mode_count[abe_pkg::MODE_SET], mode_count[abe_pkg::MODE_CLR],
             mode_count[abe_pkg::MODE_READ], mode_count[abe_pkg::MODE_FFS],
             mode_count[abe_pkg::MODE_FFC], mode_count[abe_pkg::MODE_SET_ALL],
             mode_count[abe_pkg::MODE_CLR_ALL], mode_count[abe_pkg::MODE_RESIZE]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
